### hdl/isqrt_pkg.sv
package isqrt_pkg;

	localparam int RADICAND_BITS = 31;
	localparam int PAIRS = (RADICAND_BITS + 1) / 2;
	localparam int RAD_W = 2 * PAIRS;
	localparam int ROOT_W = PAIRS;
	localparam int REM_W = PAIRS + 2;
	localparam int ROOT_OUT_W = 16;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} isqrt_data_t;

endpackage

### hdl/isqrt_step.sv
module isqrt_step import isqrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  isqrt_data_t in_data,
	output logic        out_valid,
	output isqrt_data_t out_data
);

	logic                valid_s1;
	isqrt_data_t         data_s1;
	logic [REM_W+1:0]    cand;
	logic [REM_W+1:0]    trial;
	logic [REM_W+1:0]    diff;
	logic                fits;
	isqrt_data_t         next_data;

	// One restoring step: bring down the next radicand pair and try root*4+1.
	always_comb begin
		cand  = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
		trial = (REM_W+2)'({in_data.root, 2'b01});
		fits  = (cand >= trial);
		diff  = cand - trial;
		next_data.rad  = in_data.rad << 2;
		next_data.rem  = fits ? diff[REM_W-1:0] : cand[REM_W-1:0];
		next_data.root = {in_data.root[ROOT_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= next_data;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

### hdl/integer_square_root_top.sv
// Channel   Ports                   Direction  Transaction
// command   start, busy, radicand   in         start high while busy is low
// result    done, root              out        done high for one cycle
//
// Each radicand passes through a chain of sixteen register stages, one root
// bit settled per stage, and done is the valid bit of the last stage.
// A new radicand may be started in every cycle; busy stays low.
// Reset clears only the stage valid bits; data registers are not reset.
// The receiver cannot hold results off, so nothing in the chain ever stalls.
module integer_square_root_top import isqrt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [RADICAND_BITS-1:0] radicand,
	output logic                     done,
	output logic [ROOT_OUT_W-1:0]    root
);

	logic                         stage_valid [PAIRS+1];
	isqrt_data_t                  stage_data  [PAIRS+1];
	logic [ROOT_W+ROOT_OUT_W-1:0] root_ext;

	assign busy = 1'b0;

	assign stage_valid[0]     = start;
	assign stage_data[0].rad  = RAD_W'(radicand);
	assign stage_data[0].rem  = '0;
	assign stage_data[0].root = '0;

	for (genvar g = 0; g < PAIRS; g++) begin : g_step
		isqrt_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[g]),
			.in_data   (stage_data[g]),
			.out_valid (stage_valid[g+1]),
			.out_data  (stage_data[g+1])
		);
	end

	assign root_ext = {{ROOT_OUT_W{1'b0}}, stage_data[PAIRS].root};
	assign root     = root_ext[ROOT_OUT_W-1:0];
	assign done     = stage_valid[PAIRS];

endmodule
